>>> hw/rtl/assert_macros.svh
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define A51_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define A51_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define A51_ASSERT(label, prop)
`define A51_ASSERT_RST(label, prop)
`endif
`endif

>>> hw/rtl/a51_pkg.sv
package a51_pkg;
  localparam int unsigned LinkCountWidth = 22;
  localparam int unsigned R1Len = 19;
  localparam int unsigned R2Len = 22;
  localparam int unsigned R3Len = 23;
  localparam logic [R1Len-1:0] R1Taps = 19'h72000;
  localparam logic [R2Len-1:0] R2Taps = 22'h300000;
  localparam logic [R3Len-1:0] R3Taps = 23'h700080;
  localparam int unsigned R1Mid = 8;
  localparam int unsigned R2Mid = 10;
  localparam int unsigned R3Mid = 10;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    CfgMaxLinks = 3'd0, CfgDpBits = 3'd1, CfgRoundCount = 3'd2, CfgStartAdv = 3'd3,
    CfgRfMode = 3'd4, CfgXorFirst = 3'd5, CfgXorLast = 3'd6, CfgExtraClk = 3'd7
  } cfg_idx_e;

  // Control from the sequencer to the cell row
  typedef struct packed {
    logic load;   // load cells from chain value
    logic step;   // one majority clocking
  } cell_ctl_t;
endpackage

>>> hw/rtl/a51_cell.sv
// One bit of one of the three A5/1 registers. Each cell holds one bit of R1, R2
// or R3 and shifts it to the next cell on its register's clocking.
module a51_cell import a51_pkg::*; (
  input  logic clk_i,
  input  logic load_i,
  input  logic load_bit_i,
  input  logic shift_i,
  input  logic prev_i,
  output logic bit_o
);
  logic bit_q, bit_d;
  always_comb begin
    bit_d = bit_q;
    if (load_i) begin
      bit_d = load_bit_i;
    end else if (shift_i) begin
      bit_d = prev_i;
    end
  end
  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end
  assign bit_o = bit_q;
endmodule

>>> hw/rtl/a51_keystream.sv
// Three rows of cells forming R1/R2/R3 with majority clocking; 64-bit output
// shift word collects keystream bits.
module a51_keystream import a51_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctl_t   ctl_i,
  input  logic [63:0] value_i,
  output logic [63:0] out_o
);
  logic [R1Len-1:0] r1, r1_ld;
  logic [R2Len-1:0] r2, r2_ld;
  logic [R3Len-1:0] r3, r3_ld;
  logic [R1Len-1:0] r1_prev;
  logic [R2Len-1:0] r2_prev;
  logic [R3Len-1:0] r3_prev;
  logic c1, c2, c3, maj, kb_next;
  logic [63:0] out_q, out_d;

  // Bit-reversed loading of the chain value
  always_comb begin
    for (int i = 0; i < R3Len; i++) r3_ld[R3Len-1-i] = value_i[i];
    for (int i = 0; i < R2Len; i++) r2_ld[R2Len-1-i] = value_i[R3Len+i];
    for (int i = 0; i < R1Len; i++) r1_ld[R1Len-1-i] = value_i[R3Len+R2Len+i];
  end

  assign maj = (r1[R1Mid] & r2[R2Mid]) | (r1[R1Mid] & r3[R3Mid]) | (r2[R2Mid] & r3[R3Mid]);
  assign c1 = ctl_i.step && (r1[R1Mid] == maj);
  assign c2 = ctl_i.step && (r2[R2Mid] == maj);
  assign c3 = ctl_i.step && (r3[R3Mid] == maj);

  assign r1_prev = {r1[R1Len-2:0], ^(r1 & R1Taps)};
  assign r2_prev = {r2[R2Len-2:0], ^(r2 & R2Taps)};
  assign r3_prev = {r3[R3Len-2:0], ^(r3 & R3Taps)};

  for (genvar g = 0; g < R1Len; g++) begin : g_r1
    a51_cell u_c (.clk_i, .load_i(ctl_i.load), .load_bit_i(r1_ld[g]), .shift_i(c1),
                  .prev_i(r1_prev[g]), .bit_o(r1[g]));
  end
  for (genvar g = 0; g < R2Len; g++) begin : g_r2
    a51_cell u_c (.clk_i, .load_i(ctl_i.load), .load_bit_i(r2_ld[g]), .shift_i(c2),
                  .prev_i(r2_prev[g]), .bit_o(r2[g]));
  end
  for (genvar g = 0; g < R3Len; g++) begin : g_r3
    a51_cell u_c (.clk_i, .load_i(ctl_i.load), .load_bit_i(r3_ld[g]), .shift_i(c3),
                  .prev_i(r3_prev[g]), .bit_o(r3[g]));
  end

  // Keystream bit after the clocking of this cycle
  assign kb_next = (c1 ? r1_prev[R1Len-1] : r1[R1Len-1]) ^
                   (c2 ? r2_prev[R2Len-1] : r2[R2Len-1]) ^
                   (c3 ? r3_prev[R3Len-1] : r3[R3Len-1]);

  always_comb begin
    out_d = out_q;
    if (ctl_i.load) begin
      out_d = {r1_ld[R1Len-1] ^ r2_ld[R2Len-1] ^ r3_ld[R3Len-1], 63'd0};
    end else if (ctl_i.step) begin
      out_d = {kb_next, out_q[63:1]};
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end
  assign out_o = out_q;
endmodule

>>> hw/rtl/a51_rainbow_chain_walker.sv
// A5/1 rainbow chain walker. One start_point item gives one result item.
// After the accepting edge the round value is advanced start_advance times,
// 64 LFSR shifts each (one LFSR shift a cycle), then XORed in if xor_first
// is set. Each link then XORs and tests for a distinguished point, checks the
// round count and loads the cell row, and runs 64 + extra_clocks majority
// clockings in the cell row (one majority clocking a cycle), the last of which
// hands the keystream word back. A distinguished point adds a round-function
// advance of 64 LFSR shifts. The chain ends with the final test and the
// hand-over of the item to the output register once that register is free.
// One chain is walked at a time; a finished item waits in the output
// register under out_stall_i while the next start point is already accepted
// and walked.
module a51_rainbow_chain_walker import a51_pkg::*; #(
  parameter int unsigned LINK_COUNT_WIDTH = LinkCountWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [21:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] start_point_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] end_point_o,
  output logic [7:0]  rounds_done_o,
  output logic [21:0] links_done_o,
  output logic        chain_complete_o
);
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    StIdle, StStartAdv, StLink, StRfAdv, StCheck, StMap, StFinish
  } state_e;

  localparam int unsigned LW = LINK_COUNT_WIDTH;

  logic [21:0] max_links_q;
  logic [5:0]  dp_bits_q;
  logic [7:0]  round_count_q, start_adv_q, extra_q;
  logic        rf_mode_q, xor_first_q, xor_last_q;

  state_e      state_q;
  logic [63:0] val_q, rf_q, rf_next;
  logic [5:0]  sh_cnt_q;
  logic [7:0]  adv_cnt_q;
  logic [8:0]  clk_cnt_q;
  logic [LW-1:0] rounds_q, links_q, limit;
  logic        out_valid_q, done_q;
  logic [63:0] end_point_q;
  logic [7:0]  rounds_out_q;
  logic [21:0] links_out_q;
  logic        complete_q;
  logic        fin_go;
  cell_ctl_t   ctl;
  logic [63:0] ks_out, dmask;
  logic        fb;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_links_q <= 22'd2000000; dp_bits_q <= 6'd12; round_count_q <= 8'd8;
      start_adv_q <= '0; rf_mode_q <= 1'b0; xor_first_q <= 1'b0;
      xor_last_q <= 1'b0; extra_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgMaxLinks:   max_links_q   <= cfg_data_i;
        CfgDpBits:     dp_bits_q     <= cfg_data_i[5:0];
        CfgRoundCount: round_count_q <= cfg_data_i[7:0];
        CfgStartAdv:   start_adv_q   <= cfg_data_i[7:0];
        CfgRfMode:     rf_mode_q     <= cfg_data_i[0];
        CfgXorFirst:   xor_first_q   <= cfg_data_i[0];
        CfgXorLast:    xor_last_q    <= cfg_data_i[0];
        CfgExtraClk:   extra_q       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Limit at link-counter width
  assign limit = LW'(max_links_q);

  // One LFSR shift of the round function
  assign fb = ~(rf_q[63] ^ rf_q[62] ^ rf_q[60] ^ rf_q[59]);
  assign rf_next = rf_mode_q ? {fb, rf_q[63:1]} : {rf_q[62:0], fb};
  assign dmask = ~(64'hFFFF_FFFF_FFFF_FFFF << dp_bits_q);

  assign ctl.load = (state_q == StCheck) && !(rounds_q == LW'(round_count_q));
  assign ctl.step = (state_q == StMap);

  a51_keystream u_ks (.clk_i, .rst_ni, .ctl_i(ctl), .value_i(val_q), .out_o(ks_out));

  assign in_stall_o = (state_q != StIdle);

  // Finished chain moves to the output register once it is free
  assign fin_go = (state_q == StFinish) && (!out_valid_q || !out_stall_i);

  // Chain sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; done_q <= 1'b0;
      rounds_q <= '0; links_q <= '0; sh_cnt_q <= '0; adv_cnt_q <= '0;
      clk_cnt_q <= '0; rf_q <= '0; val_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && !in_stall_o) begin
            val_q <= start_point_i; rf_q <= '0; rounds_q <= '0; links_q <= '0;
            done_q <= 1'b0; sh_cnt_q <= '0; adv_cnt_q <= '0;
            state_q <= StStartAdv;
          end
        end
        StStartAdv: begin
          if (adv_cnt_q == start_adv_q) begin
            if (xor_first_q) val_q <= val_q ^ rf_q;
            state_q <= StLink;
          end else begin
            rf_q <= rf_next; sh_cnt_q <= sh_cnt_q + 6'd1;
            if (sh_cnt_q == 6'd63) adv_cnt_q <= adv_cnt_q + 8'd1;
          end
        end
        StLink: begin
          if (links_q < limit) begin
            val_q <= val_q ^ rf_q;
            sh_cnt_q <= '0;
            if (((val_q ^ rf_q) & dmask) == 64'd0) begin
              rounds_q <= rounds_q + LW'(1);
              state_q <= StRfAdv;
            end else begin
              state_q <= StCheck;
            end
          end else begin
            if (xor_last_q) val_q <= val_q ^ rf_q;
            state_q <= StFinish;
          end
        end
        StRfAdv: begin
          rf_q <= rf_next; sh_cnt_q <= sh_cnt_q + 6'd1;
          if (sh_cnt_q == 6'd63) state_q <= StCheck;
        end
        StCheck: begin
          if (rounds_q == LW'(round_count_q)) begin
            done_q <= 1'b1; state_q <= StFinish;
          end else begin
            clk_cnt_q <= 9'd63 + {1'b0, extra_q};
            state_q <= StMap;
          end
        end
        StMap: begin
          clk_cnt_q <= clk_cnt_q - 9'd1;
          if (clk_cnt_q == 9'd0) begin
            val_q <= ks_out; links_q <= links_q + LW'(1); state_q <= StLink;
          end
        end
        StFinish: begin
          if (fin_go) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0; end_point_q <= '0; rounds_out_q <= '0;
      links_out_q <= '0; complete_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q  <= 1'b1;
      end_point_q  <= val_q;
      rounds_out_q <= (rounds_q > LW'(255)) ? 8'hFF : rounds_q[7:0];
      links_out_q  <= 22'(links_q);
      complete_q   <= done_q;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign end_point_o = end_point_q;
  assign rounds_done_o = rounds_out_q;
  assign links_done_o = links_out_q;
  assign chain_complete_o = complete_q;

  `A51_ASSERT(a_no_accept_busy, (state_q != StIdle) |-> in_stall_o)
  `A51_ASSERT(a_links_bound, (state_q == StMap) |-> (links_q < limit))
  `A51_ASSERT(a_out_hold, (out_valid_q && out_stall_i) |=> out_valid_q)
endmodule
